// ===== sv/gnms_pkg.sv =====
// ----------------------------------------------------------------------------
// gnms_pkg
// Shared types and widths for the gradient non-maximum suppression block.
// ----------------------------------------------------------------------------
package gnms_pkg;

    localparam int MAG_W  = 15;              // window magnitude width
    localparam int GRAD_W = 16;              // signed gradient width
    localparam int DIFF_W = MAG_W + 1;       // signed difference of two magnitudes
    localparam int XP_W   = GRAD_W + 1;      // negated gradient needs one more bit
    localparam int PROD_W = DIFF_W + XP_W;   // one weighted term
    localparam int SUM_W  = PROD_W + 1;      // sum of two terms

    typedef enum logic [1:0] {
        CLASS_BORDER   = 2'd0,
        CLASS_NONE     = 2'd1,
        CLASS_POSSIBLE = 2'd2
    } t_edge_class;

    // octant code: {gx negative, gy negative, nearer the x axis}
    typedef enum logic [2:0] {
        OCT_PP_Y = 3'b000,
        OCT_PP_X = 3'b001,
        OCT_PN_Y = 3'b010,
        OCT_PN_X = 3'b011,
        OCT_NP_Y = 3'b100,
        OCT_NP_X = 3'b101,
        OCT_NN_Y = 3'b110,
        OCT_NN_X = 3'b111
    } t_octant;

    // neighbour differences feeding the two interpolations
    typedef struct packed {
        logic signed [DIFF_W-1:0] a1;
        logic signed [DIFF_W-1:0] b1;
        logic signed [DIFF_W-1:0] a2;
        logic signed [DIFF_W-1:0] b2;
    } t_operands;

    function automatic logic signed [DIFF_W-1:0] mag_diff(
        input logic [MAG_W-1:0] p,
        input logic [MAG_W-1:0] q
    );
        mag_diff = $signed({1'b0, p}) - $signed({1'b0, q});
    endfunction

endpackage

// ===== sv/gnms_octant.sv =====
// ----------------------------------------------------------------------------
// gnms_octant
// Picks the gradient octant and routes the matching neighbour differences.
// ----------------------------------------------------------------------------
module gnms_octant import gnms_pkg::*; (
    input  logic [MAG_W-1:0]         i_m,
    input  logic [MAG_W-1:0]         i_n,
    input  logic [MAG_W-1:0]         i_ne,
    input  logic [MAG_W-1:0]         i_e,
    input  logic [MAG_W-1:0]         i_se,
    input  logic [MAG_W-1:0]         i_s,
    input  logic [MAG_W-1:0]         i_sw,
    input  logic [MAG_W-1:0]         i_w,
    input  logic [MAG_W-1:0]         i_nw,
    input  logic signed [GRAD_W-1:0] i_gx,
    input  logic signed [GRAD_W-1:0] i_gy,
    output t_operands                o_ops
);

    logic          gx_neg;
    logic          gy_neg;
    logic [XP_W-1:0] abs_x;
    logic [XP_W-1:0] abs_y;
    logic          near_x;
    t_octant       octant;

    assign gx_neg = i_gx[GRAD_W-1];
    assign gy_neg = i_gy[GRAD_W-1];
    assign abs_x  = gx_neg ? (XP_W'(0) - {i_gx[GRAD_W-1], i_gx}) : {1'b0, i_gx};
    assign abs_y  = gy_neg ? (XP_W'(0) - {i_gy[GRAD_W-1], i_gy}) : {1'b0, i_gy};

    // ties go to the x axis except when both gradients are negative
    assign near_x = (gx_neg && gy_neg) ? (abs_x > abs_y) : (abs_x >= abs_y);
    assign octant = t_octant'({gx_neg, gy_neg, near_x});

    always_comb begin
        case (octant)
            OCT_PP_X: begin
                o_ops.a1 = mag_diff(i_m,  i_w);  o_ops.b1 = mag_diff(i_nw, i_w);
                o_ops.a2 = mag_diff(i_m,  i_e);  o_ops.b2 = mag_diff(i_se, i_e);
            end
            OCT_PP_Y: begin
                o_ops.a1 = mag_diff(i_n,  i_nw); o_ops.b1 = mag_diff(i_n,  i_m);
                o_ops.a2 = mag_diff(i_s,  i_se); o_ops.b2 = mag_diff(i_s,  i_m);
            end
            OCT_PN_X: begin
                o_ops.a1 = mag_diff(i_m,  i_w);  o_ops.b1 = mag_diff(i_w,  i_sw);
                o_ops.a2 = mag_diff(i_m,  i_e);  o_ops.b2 = mag_diff(i_e,  i_ne);
            end
            OCT_PN_Y: begin
                o_ops.a1 = mag_diff(i_s,  i_sw); o_ops.b1 = mag_diff(i_m,  i_s);
                o_ops.a2 = mag_diff(i_n,  i_ne); o_ops.b2 = mag_diff(i_m,  i_n);
            end
            OCT_NP_X: begin
                o_ops.a1 = mag_diff(i_e,  i_m);  o_ops.b1 = mag_diff(i_ne, i_e);
                o_ops.a2 = mag_diff(i_w,  i_m);  o_ops.b2 = mag_diff(i_sw, i_w);
            end
            OCT_NP_Y: begin
                o_ops.a1 = mag_diff(i_ne, i_n);  o_ops.b1 = mag_diff(i_n,  i_m);
                o_ops.a2 = mag_diff(i_sw, i_s);  o_ops.b2 = mag_diff(i_s,  i_m);
            end
            OCT_NN_X: begin
                o_ops.a1 = mag_diff(i_e,  i_m);  o_ops.b1 = mag_diff(i_e,  i_se);
                o_ops.a2 = mag_diff(i_w,  i_m);  o_ops.b2 = mag_diff(i_w,  i_nw);
            end
            OCT_NN_Y: begin
                o_ops.a1 = mag_diff(i_se, i_s);  o_ops.b1 = mag_diff(i_m,  i_s);
                o_ops.a2 = mag_diff(i_nw, i_n);  o_ops.b2 = mag_diff(i_m,  i_n);
            end
            default: begin
                o_ops = '0;
            end
        endcase
    end

endmodule

// ===== sv/gnms_decide.sv =====
// ----------------------------------------------------------------------------
// gnms_decide
// Forms both interpolated differences and classes the pixel.
// ----------------------------------------------------------------------------
module gnms_decide import gnms_pkg::*; (
    input  t_operands                i_ops,
    input  logic signed [GRAD_W-1:0] i_gx,
    input  logic signed [GRAD_W-1:0] i_gy,
    input  logic                     i_border,
    input  logic                     i_mag_zero,
    output t_edge_class              o_class
);

    logic signed [XP_W-1:0]   xp;
    logic signed [XP_W-1:0]   yp;
    logic signed [PROD_W-1:0] p1a;
    logic signed [PROD_W-1:0] p1b;
    logic signed [PROD_W-1:0] p2a;
    logic signed [PROD_W-1:0] p2b;
    logic signed [SUM_W-1:0]  d1;
    logic signed [SUM_W-1:0]  d2;
    logic                     possible;

    assign xp = XP_W'(0) - XP_W'(i_gx);
    assign yp = XP_W'(i_gy);

    // four independent products, each difference scaled by the negated x gradient or the y gradient
    assign p1a = PROD_W'(i_ops.a1 * xp);
    assign p1b = PROD_W'(i_ops.b1 * yp);
    assign p2a = PROD_W'(i_ops.a2 * xp);
    assign p2b = PROD_W'(i_ops.b2 * yp);

    assign d1 = SUM_W'(p1a) + SUM_W'(p1b);
    assign d2 = SUM_W'(p2a) + SUM_W'(p2b);

    // edge only when neither side rises and the second is strictly below
    assign possible = (d1 <= 0) && (d2 < 0);

    always_comb begin
        if (i_border) begin
            o_class = CLASS_BORDER;
        end else if (i_mag_zero || !possible) begin
            o_class = CLASS_NONE;
        end else begin
            o_class = CLASS_POSSIBLE;
        end
    end

endmodule

// ===== sv/gradient_non_max_suppression.sv =====
// ----------------------------------------------------------------------------
// gradient_non_max_suppression
// Canny non-maximum suppression for one pixel window per item.
// Pipeline: input register, then result register. Throughput: one item per
// cycle while the sink is ready, with a single pass from the input register
// through the octant mux and four products to the result.
// Reset clears both valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
module gradient_non_max_suppression import gnms_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [MAG_W-1:0]         i_mag_center,
    input  logic [MAG_W-1:0]         i_mag_north,
    input  logic [MAG_W-1:0]         i_mag_northeast,
    input  logic [MAG_W-1:0]         i_mag_east,
    input  logic [MAG_W-1:0]         i_mag_southeast,
    input  logic [MAG_W-1:0]         i_mag_south,
    input  logic [MAG_W-1:0]         i_mag_southwest,
    input  logic [MAG_W-1:0]         i_mag_west,
    input  logic [MAG_W-1:0]         i_mag_northwest,
    input  logic signed [GRAD_W-1:0] i_grad_x,
    input  logic signed [GRAD_W-1:0] i_grad_y,
    input  logic                     i_on_border,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [1:0]               o_edge_class
);

    logic                     r_s0_valid;
    logic [MAG_W-1:0]         r_m;
    logic [MAG_W-1:0]         r_n;
    logic [MAG_W-1:0]         r_ne;
    logic [MAG_W-1:0]         r_e;
    logic [MAG_W-1:0]         r_se;
    logic [MAG_W-1:0]         r_s;
    logic [MAG_W-1:0]         r_sw;
    logic [MAG_W-1:0]         r_w;
    logic [MAG_W-1:0]         r_nw;
    logic signed [GRAD_W-1:0] r_gx;
    logic signed [GRAD_W-1:0] r_gy;
    logic                     r_border;

    logic                     r_out_valid;
    t_edge_class              r_class;
    t_edge_class              n_class;

    t_operands                ops;
    logic                     advance;

    assign advance = !r_out_valid || i_ready;
    assign o_ready = !r_s0_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s0_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= r_s0_valid;
            end
        end
    end

    // hold the window while the stage is stalled
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_m      <= i_mag_center;
            r_n      <= i_mag_north;
            r_ne     <= i_mag_northeast;
            r_e      <= i_mag_east;
            r_se     <= i_mag_southeast;
            r_s      <= i_mag_south;
            r_sw     <= i_mag_southwest;
            r_w      <= i_mag_west;
            r_nw     <= i_mag_northwest;
            r_gx     <= i_grad_x;
            r_gy     <= i_grad_y;
            r_border <= i_on_border;
        end
    end

    gnms_octant u_octant (
        .i_m   (r_m),
        .i_n   (r_n),
        .i_ne  (r_ne),
        .i_e   (r_e),
        .i_se  (r_se),
        .i_s   (r_s),
        .i_sw  (r_sw),
        .i_w   (r_w),
        .i_nw  (r_nw),
        .i_gx  (r_gx),
        .i_gy  (r_gy),
        .o_ops (ops)
    );

    gnms_decide u_decide (
        .i_ops      (ops),
        .i_gx       (r_gx),
        .i_gy       (r_gy),
        .i_border   (r_border),
        .i_mag_zero (r_m == '0),
        .o_class    (n_class)
    );

    always_ff @(posedge i_clk) begin
        if (advance && r_s0_valid) begin
            r_class <= n_class;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_edge_class = r_class;

endmodule

// ===== sv/gnms_checker.sv =====
// ----------------------------------------------------------------------------
// gnms_checker
// Port-level checks for the non-maximum suppression block, bound to the top.
// ----------------------------------------------------------------------------
module gnms_checker import gnms_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       i_on_border,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_edge_class
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_edge_class))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_no_code3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_edge_class != 2'd3)
        else $error("unused class code on output");

    // with the sink ready, an accepted item shows after the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_ready) ##1 i_ready |=> o_valid)
        else $error("result missing two cycles after item");

    a_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_ready && i_on_border) ##1 i_ready
            |=> o_edge_class == CLASS_BORDER)
        else $error("border item not classed as border");

endmodule

bind gradient_non_max_suppression gnms_checker u_gnms_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .i_on_border  (i_on_border),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_edge_class (o_edge_class)
);
